// ===== rtl/fixed_frame_deframer_router_defines.svh =====
// Assertion macros shared by the deframer router RTL.
`ifndef FIXED_FRAME_DEFRAMER_ROUTER_DEFINES_SVH
`define FIXED_FRAME_DEFRAMER_ROUTER_DEFINES_SVH

// Same-cycle implication, checked on i_clk and disabled during i_rst_n low.
`define FFDR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and disabled during i_rst_n low.
`define FFDR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffdr_pkg.sv =====
// Types and constants of the fixed-frame deframer router.
`timescale 1ns / 1ps

package ffdr_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int PIDX_W        = $clog2(PAYLOAD_BYTES);
    localparam int CFG_IDX_W     = 3;

    // Frame markers
    localparam logic [7:0] MARK_START1 = 8'h41;
    localparam logic [7:0] MARK_START2 = 8'h5A;
    localparam logic [7:0] MARK_END1   = 8'h59;
    localparam logic [7:0] MARK_END2   = 8'h42;

    // System ids
    localparam logic [7:0] ID_TO_BASE = 8'h01;
    localparam logic [7:0] ID_TO_ARM  = 8'h02;
    localparam logic [7:0] ID_ARM_UP  = 8'h03;

    // Event codes
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_LOCAL      = 3'd1;
    localparam logic [2:0] EV_FWD_ARM    = 3'd2;
    localparam logic [2:0] EV_FWD_BRIDGE = 3'd3;
    localparam logic [2:0] EV_DROP       = 3'd4;
    localparam logic [2:0] EV_FRAMING    = 3'd5;
    localparam logic [2:0] EV_UNKNOWN    = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE_IS_ARM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ENABLED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE_PRESENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_PRESENT    = 3'd3;

    typedef struct packed {
        logic       stream_id;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_code;
        logic        from_stream;
        logic [7:0]  system_id;
        logic [7:0]  mode_byte;
        logic [15:0] x_value;
        logic [15:0] y_value;
        logic [7:0]  z_direction;
        logic [7:0]  yaw_byte;
        logic [15:0] error_total;
    } t_out_item;

endpackage

// ===== rtl/fixed_frame_deframer_router.sv =====
// Byte-stream deframer with per-stream parsers, shared error counter and frame router.
`timescale 1ns / 1ps
`include "fixed_frame_deframer_router_defines.svh"

// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one byte per request,
//   tagged with its stream. Each stream runs its own parser: 0x41 0x5A, eight
//   payload bytes, 0x59 0x42. Every accepted byte yields exactly one result on
//   the output channel (o_out_valid / i_out_ready / o_out): an event code, the
//   stream, the frame payload on routing events (zero otherwise) and the
//   running error total.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the four 1-bit
//   routing registers; write it only while no byte is in flight.
//   Path: each byte passes through the input register, then one parse/route
//   step into the result register.
//   Throughput: one byte per cycle while results are taken; the per-stream
//   parse step and the error counter update close in the same step, so bytes
//   of the same stream can follow back to back.
//   Reset (i_rst_n low, synchronous): all parsers wait for the first start
//   marker, the error counter clears, role_is_arm = 1, other routing registers 0.
//   Receiver stall: the result register holds; the input register still takes
//   one more byte, then o_in_ready drops until the result is taken.
module fixed_frame_deframer_router #(
    parameter int NUM_STREAMS = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ffdr_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ffdr_pkg::t_out_item             o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ffdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                            i_cfg_data
);

    typedef enum logic [2:0] {
        PH_START1,
        PH_START2,
        PH_BODY,
        PH_END1,
        PH_END2
    } t_phase;

    typedef logic [7:0] t_payload [ffdr_pkg::PAYLOAD_BYTES];

    // Configuration
    logic r_role_is_arm;
    logic r_local_enabled;
    logic r_bridge_present;
    logic r_arm_present;

    // Input register
    logic               r_in_valid;
    ffdr_pkg::t_in_item r_in;

    // Per-stream parser state
    t_phase                      r_phase  [NUM_STREAMS];
    t_phase                      n_phase  [NUM_STREAMS];
    logic [ffdr_pkg::PIDX_W-1:0] r_pidx   [NUM_STREAMS];
    logic [ffdr_pkg::PIDX_W-1:0] n_pidx   [NUM_STREAMS];
    t_payload                    r_pstore [NUM_STREAMS];
    t_payload                    n_pstore [NUM_STREAMS];

    logic [15:0] r_err_cnt;
    logic [15:0] n_err_cnt;

    // Result register
    logic                r_out_valid;
    ffdr_pkg::t_out_item r_out;
    ffdr_pkg::t_out_item n_out;

    logic     w_proc;
    logic     w_inc;
    logic     w_frame;
    logic [2:0] w_ev;
    t_payload w_pl;

    function automatic logic [2:0] route(input logic [7:0] id, input logic arm_role,
                                         input logic local_en, input logic bridge_ok,
                                         input logic arm_ok);
        logic [2:0] ev;
        ev = ffdr_pkg::EV_UNKNOWN;
        if (arm_role) begin
            if (id == ffdr_pkg::ID_TO_ARM) begin
                ev = local_en ? ffdr_pkg::EV_LOCAL : ffdr_pkg::EV_DROP;
            end else if (id == ffdr_pkg::ID_TO_BASE) begin
                ev = ffdr_pkg::EV_DROP;
            end else if (id == ffdr_pkg::ID_ARM_UP) begin
                ev = bridge_ok ? ffdr_pkg::EV_FWD_BRIDGE : ffdr_pkg::EV_DROP;
            end
        end else begin
            if (id == ffdr_pkg::ID_TO_BASE) begin
                ev = local_en ? ffdr_pkg::EV_LOCAL : ffdr_pkg::EV_DROP;
            end else if (id == ffdr_pkg::ID_TO_ARM) begin
                ev = arm_ok ? ffdr_pkg::EV_FWD_ARM : ffdr_pkg::EV_DROP;
            end else if (id == ffdr_pkg::ID_ARM_UP) begin
                ev = bridge_ok ? ffdr_pkg::EV_FWD_BRIDGE : ffdr_pkg::EV_DROP;
            end
        end
        return ev;
    endfunction

    // Advance the input stage when the result register is free or being drained.
    assign w_proc      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_proc;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Parse step: only the lane of the current stream moves.
    always_comb begin
        n_phase  = r_phase;
        n_pidx   = r_pidx;
        n_pstore = r_pstore;
        w_ev     = ffdr_pkg::EV_NONE;
        w_frame  = 1'b0;
        w_pl     = r_pstore[0];
        for (int s = 0; s < NUM_STREAMS; s++) begin
            if (w_proc && (int'(r_in.stream_id) == s)) begin
                w_pl = r_pstore[s];
                case (r_phase[s])
                    PH_START1: begin
                        if (r_in.rx_byte == ffdr_pkg::MARK_START1) begin
                            n_phase[s] = PH_START2;
                        end
                    end
                    PH_START2: begin
                        if (r_in.rx_byte == ffdr_pkg::MARK_START2) begin
                            n_pidx[s]  = '0;
                            n_phase[s] = PH_BODY;
                        end else begin
                            w_ev = ffdr_pkg::EV_FRAMING;
                            // A repeated start marker keeps the parser armed.
                            if (r_in.rx_byte != ffdr_pkg::MARK_START1) begin
                                n_phase[s] = PH_START1;
                                n_pidx[s]  = '0;
                            end
                        end
                    end
                    PH_BODY: begin
                        n_pstore[s][r_pidx[s]] = r_in.rx_byte;
                        n_pidx[s] = ffdr_pkg::PIDX_W'(r_pidx[s] + 1'b1);
                        if (r_pidx[s] == ffdr_pkg::PIDX_W'(ffdr_pkg::PAYLOAD_BYTES - 1)) begin
                            n_phase[s] = PH_END1;
                        end
                    end
                    PH_END1: begin
                        if (r_in.rx_byte == ffdr_pkg::MARK_END1) begin
                            n_phase[s] = PH_END2;
                        end else begin
                            w_ev       = ffdr_pkg::EV_FRAMING;
                            n_phase[s] = PH_START1;
                            n_pidx[s]  = '0;
                        end
                    end
                    PH_END2: begin
                        if (r_in.rx_byte == ffdr_pkg::MARK_END2) begin
                            w_frame = 1'b1;
                            w_ev    = route(r_pstore[s][0], r_role_is_arm, r_local_enabled,
                                            r_bridge_present, r_arm_present);
                        end else begin
                            w_ev = ffdr_pkg::EV_FRAMING;
                        end
                        n_phase[s] = PH_START1;
                        n_pidx[s]  = '0;
                    end
                    default: begin
                        n_phase[s] = PH_START1;
                        n_pidx[s]  = '0;
                    end
                endcase
            end
        end
    end

    assign w_inc     = (w_ev == ffdr_pkg::EV_FRAMING) || (w_ev == ffdr_pkg::EV_UNKNOWN);
    assign n_err_cnt = r_err_cnt + {15'd0, w_inc};

    always_comb begin
        n_out             = '0;
        n_out.event_code  = w_ev;
        n_out.from_stream = r_in.stream_id;
        n_out.error_total = n_err_cnt;
        if (w_frame) begin
            n_out.system_id   = w_pl[0];
            n_out.mode_byte   = w_pl[1];
            n_out.x_value     = {w_pl[2], w_pl[3]};
            n_out.y_value     = {w_pl[4], w_pl[5]};
            n_out.z_direction = w_pl[6];
            n_out.yaw_byte    = w_pl[7];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role_is_arm    <= 1'b1;
            r_local_enabled  <= 1'b0;
            r_bridge_present <= 1'b0;
            r_arm_present    <= 1'b0;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_err_cnt        <= '0;
            for (int s = 0; s < NUM_STREAMS; s++) begin
                r_phase[s] <= PH_START1;
                r_pidx[s]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ffdr_pkg::CFG_ROLE_IS_ARM:    r_role_is_arm    <= i_cfg_data;
                    ffdr_pkg::CFG_LOCAL_ENABLED:  r_local_enabled  <= i_cfg_data;
                    ffdr_pkg::CFG_BRIDGE_PRESENT: r_bridge_present <= i_cfg_data;
                    ffdr_pkg::CFG_ARM_PRESENT:    r_arm_present    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_err_cnt <= n_err_cnt;
            r_phase   <= n_phase;
            r_pidx    <= n_pidx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pstore <= n_pstore;
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    `FFDR_ASSERT_IMP(a_err_total_tracks, r_out_valid, r_out.error_total == r_err_cnt,
        "result error total differs from error counter")
    `FFDR_ASSERT_NXT(a_err_inc, w_proc && w_inc, r_err_cnt == $past(r_err_cnt) + 16'd1,
        "error counter did not advance on an error event")
    `FFDR_ASSERT_NXT(a_err_hold, !(w_proc && w_inc), r_err_cnt == $past(r_err_cnt),
        "error counter moved without an error event")
    `FFDR_ASSERT_IMP(a_nonframe_zero,
        r_out_valid && (r_out.event_code == ffdr_pkg::EV_NONE ||
                        r_out.event_code == ffdr_pkg::EV_FRAMING),
        r_out.system_id == 8'd0 && r_out.x_value == 16'd0 && r_out.yaw_byte == 8'd0,
        "payload fields set on a non-frame event")
    `FFDR_ASSERT_NXT(a_in_hold, r_in_valid && !w_proc, r_in_valid && $stable(r_in),
        "pending input request lost or overwritten")

endmodule
